/* hdl/lsa_pkg.sv */
// Shared types, constants and helpers of the light style animator.
package lsa_pkg;

  // Fixed field widths
  localparam int FrameW   = 32;
  localparam int FracW    = 8;
  localparam int LevelW   = 10;
  localparam int LetterW  = 5;
  localparam int StyleW   = 6;
  localparam int PosInW   = 6;
  localparam int LenInW   = 7;

  localparam int LetterMax    = 25;
  localparam int LevelUnused  = 264;
  localparam int LenFieldMax  = 127;
  localparam int EmitMax      = 64;

  // Remainder unit: quotient bits resolved per cycle
  localparam int ModStepBits  = 8;

  localparam int QueueDepth   = 2;

  localparam int NumStylesDef  = 64;
  localparam int MaxPatternDef = 64;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [StyleW-1:0]   style;
    logic [PosInW-1:0]   position;
    logic [LetterW-1:0]  letter;
    logic [LenInW-1:0]   len;
    logic [FrameW-1:0]   frame;
    logic [FracW-1:0]    fraction;
  } cmd_t;

  // 22 * letter as 16 + 4 + 2
  function automatic logic [LevelW-1:0] step_level(input logic [LetterW-1:0] l);
    return {1'b0, l, 4'b0000} + {3'b000, l, 2'b00} + {4'b0000, l, 1'b0};
  endfunction

endpackage

/* hdl/lsa_front.sv */
// Input stage: accepts beats, saturates fields, drops items that do nothing.
module lsa_front #(
  parameter int NUM_STYLES  = lsa_pkg::NumStylesDef,
  parameter int MAX_PATTERN = lsa_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [lsa_pkg::StyleW-1:0]    style_i,
  input  logic [lsa_pkg::PosInW-1:0]    position_i,
  input  logic [lsa_pkg::LetterW-1:0]   letter_i,
  input  logic [lsa_pkg::LenInW-1:0]    pattern_length_i,
  input  logic [lsa_pkg::FrameW-1:0]    frame_i,
  input  logic [lsa_pkg::FracW-1:0]     fraction_i,
  output lsa_pkg::cmd_t                 cmd_o,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i
);
  import lsa_pkg::*;

  localparam int LenMax = (MAX_PATTERN < LenFieldMax) ? MAX_PATTERN : LenFieldMax;

  cmd_t cmd_new, cmd_q;
  logic valid_q, valid_d;
  logic keep, accept;

  always_comb begin
    cmd_new.kind     = kind_e'(kind_i);
    cmd_new.style    = style_i;
    cmd_new.position = position_i;
    cmd_new.letter   = (letter_i > LetterW'(LetterMax)) ? LetterW'(LetterMax) : letter_i;
    cmd_new.len      = (int'(pattern_length_i) > LenMax) ? LenInW'(LenMax)
                                                         : pattern_length_i;
    cmd_new.frame    = frame_i;
    cmd_new.fraction = fraction_i;
  end

  always_comb begin
    case (kind_e'(kind_i))
      KIND_LETTER: begin
        keep = (int'(style_i) < NUM_STYLES) && (int'(position_i) < MAX_PATTERN);
      end
      KIND_LENGTH: begin
        keep = int'(style_i) < NUM_STYLES;
      end
      KIND_TICK: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign valid_d    = (valid_q && !cmd_ready_i) || (accept && keep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_new;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = valid_q;

endmodule

/* hdl/lsa_fifo.sv */
// Short command queue between the input stage and the execution engine.
module lsa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsa_pkg::cmd_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output lsa_pkg::cmd_t  pop_data_o
);
  import lsa_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // the engine only pops what is there
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

endmodule

/* hdl/lsa_mod.sv */
// Iterative remainder unit: frame mod length, several quotient bits per cycle.
module lsa_mod #(
  parameter int DivW = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsa_pkg::FrameW-1:0]  dividend_i,
  input  logic [DivW-1:0]             divisor_i,
  output logic                        done_o,
  output logic [DivW-1:0]             rem_o
);
  import lsa_pkg::*;

  localparam int Iters = FrameW / ModStepBits;
  localparam int CntW  = (Iters > 1) ? $clog2(Iters) : 1;

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [FrameW-1:0] sh_q, sh_n;
  logic [DivW-1:0]   rem_q, rem_n, div_q;

  // restoring steps, remainder stays below the divisor
  always_comb begin
    logic [DivW:0] t;
    rem_n = rem_q;
    sh_n  = sh_q;
    for (int i = 0; i < ModStepBits; i++) begin
      t = {rem_n, sh_n[FrameW-1]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_n = t[DivW-1:0];
      sh_n  = {sh_n[FrameW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Iters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      sh_q  <= sh_n;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < div_q)
    else $error("remainder not below divisor");

endmodule

/* hdl/lsa_back.sv */
// Execution engine: pattern and length stores, per-style walk, blend, result register.
module lsa_back #(
  parameter int NUM_STYLES  = lsa_pkg::NumStylesDef,
  parameter int MAX_PATTERN = lsa_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsa_pkg::cmd_t                 cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsa_pkg::StyleW-1:0]    out_style_o,
  output logic [lsa_pkg::LevelW-1:0]    level_o,
  output logic                          last_o
);
  import lsa_pkg::*;

  localparam int NumEmit  = (NUM_STYLES < EmitMax) ? NUM_STYLES : EmitMax;
  localparam int StyW     = (NumEmit > 1) ? $clog2(NumEmit) : 1;
  localparam int PosW     = $clog2(MAX_PATTERN);
  localparam int LenMax   = (MAX_PATTERN < LenFieldMax) ? MAX_PATTERN : LenFieldMax;
  localparam int LenW     = $clog2(LenMax + 1);
  localparam int LenDepth = 2 ** StyW;
  localparam int PatDepth = 2 ** (StyW + PosW);
  localparam int ProdW    = LevelW + FracW + 2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LEN  = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_RDA  = 5'b01000,
    ST_RDB  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // length store, zero until written (valid bits)
  logic [LenW-1:0]     len_mem [LenDepth];
  logic [LenDepth-1:0] len_vld_q;
  logic [LenW-1:0]     len_rd_q, len_n;
  logic                len_rd_vld_q;
  logic                len_we, len_re;
  logic [StyW-1:0]     len_waddr, len_raddr;

  // pattern store, undefined until written
  logic [LetterW-1:0]   pat_mem [PatDepth];
  logic [LetterW-1:0]   pat_rd_q;
  logic                 pat_we, pat_re;
  logic [StyW+PosW-1:0] pat_waddr, pat_raddr;

  logic [StyW-1:0]   sty_q, sty_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic [PosW-1:0]   k1_q, k1_d;
  logic [LevelW-1:0] a_q, a_d;
  logic              last_sty;

  logic            mod_start, mod_done;
  logic [LenW-1:0] mod_rem;
  logic [LenW:0]   k_next;

  logic                     out_valid_q, out_free, load_out;
  logic [StyleW-1:0]        out_style_q;
  logic [LevelW-1:0]        level_q, level_n;
  logic                     last_q;

  logic [LevelW-1:0]        b_val;
  logic signed [LevelW:0]   diff;
  logic signed [ProdW-1:0]  prod, blend;

  lsa_mod #(
    .DivW (LenW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (frame_q),
    .divisor_i  (len_n),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign len_n    = len_rd_vld_q ? len_rd_q : '0;
  assign last_sty = sty_q == StyW'(NumEmit - 1);
  assign out_free = !out_valid_q || out_ready_i;
  assign k_next   = {1'b0, mod_rem} + (LenW + 1)'(1);

  // a*(256-f) + b*f == a*256 + (b-a)*f
  assign b_val = step_level(pat_rd_q);
  assign diff  = $signed({1'b0, b_val}) - $signed({1'b0, a_q});
  assign prod  = diff * $signed({1'b0, frac_q});
  assign blend = $signed({2'b00, a_q, {FracW{1'b0}}}) + prod;

  always_comb begin
    state_d   = state_q;
    sty_d     = sty_q;
    frame_d   = frame_q;
    frac_d    = frac_q;
    k1_d      = k1_q;
    a_d       = a_q;
    cmd_pop_o = 1'b0;
    len_we    = 1'b0;
    len_re    = 1'b0;
    len_waddr = StyW'(cmd_i.style);
    len_raddr = sty_q;
    pat_we    = 1'b0;
    pat_re    = 1'b0;
    pat_waddr = {StyW'(cmd_i.style), PosW'(cmd_i.position)};
    pat_raddr = {sty_q, PosW'(mod_rem)};
    mod_start = 1'b0;
    load_out  = 1'b0;
    level_n   = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_LETTER: begin
              pat_we = 1'b1;
            end
            KIND_LENGTH: begin
              len_we = 1'b1;
            end
            KIND_TICK: begin
              frame_d   = cmd_i.frame;
              frac_d    = cmd_i.fraction;
              sty_d     = '0;
              len_re    = 1'b1;
              len_raddr = '0;
              state_d   = ST_LEN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LEN: begin
        if (len_n == '0) begin
          if (out_free) begin
            load_out = 1'b1;
            level_n  = LevelW'(LevelUnused);
          end
        end else begin
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          pat_re  = 1'b1;
          k1_d    = (k_next == {1'b0, len_n}) ? '0 : PosW'(k_next);
          state_d = ST_RDA;
        end
      end
      ST_RDA: begin
        a_d       = step_level(pat_rd_q);
        pat_re    = 1'b1;
        pat_raddr = {sty_q, k1_q};
        state_d   = ST_RDB;
      end
      ST_RDB: begin
        if (out_free) begin
          load_out = 1'b1;
          level_n  = blend[LevelW+FracW-1:FracW];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // next style, or back to the queue after the last one
    if (load_out) begin
      if (last_sty) begin
        state_d = ST_IDLE;
      end else begin
        sty_d     = sty_q + StyW'(1);
        len_re    = 1'b1;
        len_raddr = sty_q + StyW'(1);
        state_d   = ST_LEN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_vld_q    <= '0;
      len_rd_vld_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (len_we) begin
        len_vld_q[len_waddr] <= 1'b1;
      end
      if (len_re) begin
        len_rd_vld_q <= len_vld_q[len_raddr];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= LenW'(cmd_i.len);
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= cmd_i.letter;
    end
    if (pat_re) begin
      pat_rd_q <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    sty_q   <= sty_d;
    frame_q <= frame_d;
    frac_q  <= frac_d;
    k1_q    <= k1_d;
    a_q     <= a_d;
    if (load_out) begin
      out_style_q <= StyleW'(sty_q);
      level_q     <= level_n;
      last_q      <= last_sty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_style_o = out_style_q;
  assign level_o     = level_q;
  assign last_o      = last_q;

  // never divide by an empty length
  a_mod_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |-> len_n != '0)
    else $error("remainder started with zero length");

endmodule

/* hdl/light_style_animator_top.sv */
// Top level of the light style animator: input stage, command queue, execution engine.
//
// Light style animator. Input beats are letter writes (kind 0), length writes
// (kind 1) and ticks (kind 2); kind 3 and out-of-range writes are swallowed.
// Writes give no result; a tick gives one result beat per style, in index
// order, min(NUM_STYLES, 64) beats, with last set on the final one. A style of
// length 0 reads 264, otherwise the level is the blend of 22 times the letters
// at frame mod n and (frame+1) mod n, weighted by fraction/256 and truncated.
// A write is handled in the idle state and does not leave it. A tick loads
// its frame and fraction, then walks the styles in order: an unused style
// loads 264 into the result register, and a used style runs the remainder
// unit, which resolves 8 quotient bits of the 32-bit frame per cycle,
// followed by two single-port reads of the pattern store and the blend. A
// two-entry queue sits between the input stage and the engine, so input
// beats can still be taken while a tick is walking its styles, until the
// queue and the input stage fill up, and a result register lets the engine
// move on to the next style while a level waits to be taken. Letters read
// from pattern entries that were never written are unspecified; lengths
// reset to zero and need no clearing pass.
module light_style_animator_top #(
  parameter int NUM_STYLES  = lsa_pkg::NumStylesDef,
  parameter int MAX_PATTERN = lsa_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [lsa_pkg::StyleW-1:0]    style_i,
  input  logic [lsa_pkg::PosInW-1:0]    position_i,
  input  logic [lsa_pkg::LetterW-1:0]   letter_i,
  input  logic [lsa_pkg::LenInW-1:0]    pattern_length_i,
  input  logic [lsa_pkg::FrameW-1:0]    frame_i,
  input  logic [lsa_pkg::FracW-1:0]     fraction_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsa_pkg::StyleW-1:0]    out_style_o,
  output logic [lsa_pkg::LevelW-1:0]    level_o,
  output logic                          last_o
);
  import lsa_pkg::*;

  // input stage -> queue
  cmd_t front_cmd;
  logic front_valid, front_ready;

  // queue -> engine
  cmd_t q_cmd;
  logic q_valid, q_pop;

  lsa_front #(
    .NUM_STYLES  (NUM_STYLES),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .style_i          (style_i),
    .position_i       (position_i),
    .letter_i         (letter_i),
    .pattern_length_i (pattern_length_i),
    .frame_i          (frame_i),
    .fraction_i       (fraction_i),
    .cmd_o            (front_cmd),
    .cmd_valid_o      (front_valid),
    .cmd_ready_i      (front_ready)
  );

  lsa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_cmd)
  );

  lsa_back #(
    .NUM_STYLES  (NUM_STYLES),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_style_o (out_style_o),
    .level_o     (level_o),
    .last_o      (last_o)
  );

endmodule

/* sim/light_style_animator_top_test.sv */
// Self-checking testbench for the light style animator: letter, length and tick beats.
module light_style_animator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsa_pkg::*;

  localparam int NumStyles  = 64;
  localparam int MaxPattern = 64;
  localparam int unsigned LevelStep = 22;
  // kind code outside the enum; the block drops it silently
  localparam logic [1:0] KindIgnored = 2'd3;

  localparam int RandomItems = 180;
  // watchdog bound on the whole run: ticks, writes and stalls, taken several times over
  localparam int CycleLimit  = 400000;
  localparam int TailCycles  = 600;     // one full tick walk plus margin
  localparam int HoldCycles  = 400;     // long receiver hold-off

  typedef struct {
    logic [1:0]         kind;
    logic [StyleW-1:0]  style;
    logic [PosInW-1:0]  position;
    logic [LetterW-1:0] letter;
    logic [LenInW-1:0]  len;
    logic [FrameW-1:0]  frame;
    logic [FracW-1:0]   fraction;
  } animator_beat_t;

  typedef struct {
    logic [StyleW-1:0] style;
    logic [LevelW-1:0] level;
    logic              last;
  } level_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind_in = '0;
  logic [StyleW-1:0]  style_in = '0;
  logic [PosInW-1:0]  position_in = '0;
  logic [LetterW-1:0] letter_in = '0;
  logic [LenInW-1:0]  length_in = '0;
  logic [FrameW-1:0]  frame_in = '0;
  logic [FracW-1:0]   fraction_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StyleW-1:0]  out_style;
  logic [LevelW-1:0]  level_out;
  logic               last_out;

  light_style_animator_top #(
    .NUM_STYLES (NumStyles),
    .MAX_PATTERN(MaxPattern)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind_in),
    .style_i         (style_in),
    .position_i      (position_in),
    .letter_i        (letter_in),
    .pattern_length_i(length_in),
    .frame_i         (frame_in),
    .fraction_i      (fraction_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_style_o     (out_style),
    .level_o         (level_out),
    .last_o          (last_out)
  );

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping. The plan_* arrays track what the store will hold once
  // all queued beats are in, so no tick ever reads a letter never written.
  // ---------------------------------------------------------------------------
  animator_beat_t pending_beats[$];
  level_beat_t    expected_levels[$];

  logic [LenInW-1:0] plan_len [NumStyles];
  bit                plan_written [NumStyles*MaxPattern];
  int                planned_items = 0;

  int  total_beats = 0;
  int  beats_accepted = 0;
  bit  stim_ready = 1'b0;
  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;

  // Predictor state: lengths reset to zero, letters unknown until written
  logic [LenInW-1:0]  model_len [NumStyles];
  logic [LetterW-1:0] model_letter [NumStyles*MaxPattern];

  // Idle percentages per phase: sender rare / receiver heavy, then swapped, then none
  int sender_idle_pct;
  int receiver_idle_pct;
  always_comb begin
    if (beats_accepted < total_beats / 3) begin
      sender_idle_pct = 7;
      receiver_idle_pct = 79;
    end else if (beats_accepted < (2 * total_beats) / 3) begin
      sender_idle_pct = 79;
      receiver_idle_pct = 7;
    end else begin
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat builders. All fields a beat does not use still get random values, so
  // every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic animator_beat_t random_beat(logic [1:0] kind);
    animator_beat_t b;
    b.kind     = kind;
    b.style    = StyleW'($urandom);
    b.position = PosInW'($urandom);
    b.letter   = LetterW'($urandom);
    b.len      = LenInW'($urandom);
    b.frame    = $urandom;
    b.fraction = FracW'($urandom);
    return b;
  endfunction

  task automatic queue_letter(int s, int p, int l);
    animator_beat_t b;
    b = random_beat(KIND_LETTER);
    b.style    = StyleW'(s);
    b.position = PosInW'(p);
    b.letter   = LetterW'(l);
    pending_beats.push_back(b);
    plan_written[s*MaxPattern + p] = 1'b1;
    planned_items++;
  endtask

  // Setting a length also fills any unwritten letters the tick walk could read
  task automatic queue_length(int s, int n);
    animator_beat_t b;
    int eff;
    b = random_beat(KIND_LENGTH);
    b.style = StyleW'(s);
    b.len   = LenInW'(n);
    pending_beats.push_back(b);
    planned_items++;
    eff = (n > MaxPattern) ? MaxPattern : n;
    plan_len[s] = LenInW'(eff);
    for (int p = 0; p < eff; p++) begin
      if (!plan_written[s*MaxPattern + p])
        queue_letter(s, p, $urandom_range(0, 31));
    end
  endtask

  task automatic queue_tick(logic [FrameW-1:0] frame, logic [FracW-1:0] frac);
    animator_beat_t b;
    b = random_beat(KIND_TICK);
    b.frame    = frame;
    b.fraction = frac;
    pending_beats.push_back(b);
    planned_items++;
  endtask

  task automatic queue_ignored();
    pending_beats.push_back(random_beat(KindIgnored));
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: level of one style for a given frame and fraction.
  // ---------------------------------------------------------------------------
  function automatic logic [LevelW-1:0] style_brightness(int s, logic [FrameW-1:0] frame,
                                                         logic [FracW-1:0] frac);
    int unsigned n, k0, k1, a, b, f;
    n = 32'(model_len[s]);
    if (n == 0) return LevelW'(LevelUnused);
    if (n == 1) return LevelW'(LevelStep * 32'(model_letter[s*MaxPattern]));
    k0 = frame % n;
    k1 = (k0 + 1 == n) ? 0 : k0 + 1;   // wraps even past frame 0xFFFFFFFF
    a = LevelStep * 32'(model_letter[s*MaxPattern + k0]);
    b = LevelStep * 32'(model_letter[s*MaxPattern + k1]);
    f = 32'(frac);
    return LevelW'((a * (256 - f) + b * f) >> 8);
  endfunction

  // Applies one accepted beat to the model; a tick queues one level per style
  task automatic apply_beat(animator_beat_t b);
    level_beat_t e;
    int l, n;
    case (b.kind)
      KIND_LETTER: begin
        l = (int'(b.letter) > LetterMax) ? LetterMax : int'(b.letter);
        model_letter[int'(b.style)*MaxPattern + int'(b.position)] = LetterW'(l);
      end
      KIND_LENGTH: begin
        n = (int'(b.len) > MaxPattern) ? MaxPattern : int'(b.len);
        model_len[b.style] = LenInW'(n);
      end
      KIND_TICK: begin
        for (int s = 0; s < NumStyles; s++) begin
          e.style = StyleW'(s);
          e.level = style_brightness(s, b.frame, b.fraction);
          e.last  = (s == NumStyles - 1);
          expected_levels.push_back(e);
        end
      end
      default: ;  // ignored kind: no state change, no result
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes the model step on acceptance, then offers the next beat.
  // Valid stays up with a frozen payload until the beat is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    animator_beat_t nxt;
    bit taken;
    taken = in_valid && in_ready;
    if (taken) begin
      apply_beat('{kind_in, style_in, position_in, letter_in, length_in, frame_in, fraction_in});
      beats_accepted <= beats_accepted + 1;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !taken) begin
      // hold current beat
    end else if (stim_ready && pending_beats.size() != 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
      nxt = pending_beats.pop_front();
      in_valid    <= 1'b1;
      kind_in     <= nxt.kind;
      style_in    <= nxt.style;
      position_in <= nxt.position;
      letter_in   <= nxt.letter;
      length_in   <= nxt.len;
      frame_in    <= nxt.frame;
      fraction_in <= nxt.fraction;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once, late in the no-idle phase, the receiver holds off
  // while the sender keeps pushing, so the result register and the command
  // queue fill and in_ready drops.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n && !hold_done && total_beats != 0 &&
        beats_accepted >= (5 * total_beats) / 6) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= receiver_idle_pct;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat against the oldest expected level.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    level_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected result beat, style", int'(out_style), -1);
      end else begin
        e = expected_levels.pop_front();
        if (out_style !== e.style)
          report_mismatch("out_style", int'(out_style), int'(e.style));
        if (level_out !== e.level)
          report_mismatch($sformatf("level of style %0d", e.style), int'(level_out),
                          int'(e.level));
        if (last_out !== e.last)
          report_mismatch($sformatf("last of style %0d", e.style), int'(last_out),
                          int'(e.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int r, start_items;
    logic [FrameW-1:0] fr;
    for (int s = 0; s < NumStyles; s++) begin
      plan_len[s] = '0;
      model_len[s] = '0;
    end

    // Directed part
    queue_tick(32'd0, 8'd0);                  // every style unused after reset
    queue_ignored();
    queue_letter(0, 0, 31);                   // letter above 25 saturates
    queue_length(0, 1);                       // single-letter style
    queue_letter(1, 0, 0);
    queue_letter(1, 1, 25);
    queue_length(1, 2);
    queue_length(63, 127);                    // length above 64 saturates
    queue_letter(63, 63, 25);
    queue_letter(63, 0, 0);
    queue_length(5, 3);
    queue_tick(32'hFFFF_FFFF, 8'd255);        // next position wraps past max frame
    queue_tick(32'd63, 8'd128);
    queue_ignored();
    queue_tick(32'd64, 8'd0);
    queue_length(5, 0);                       // back to unused
    queue_tick(32'd1, 8'd1);
    queue_tick(32'hFFFF_FFFE, 8'd255);

    // Random part: mostly well-formed pattern edits followed by ticks
    start_items = planned_items;
    while (planned_items < start_items + RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_letter($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31));
      end else if (r < 65) begin
        r = $urandom_range(0, 99);
        if (r < 60)      queue_length($urandom_range(0, 63), $urandom_range(0, 6));
        else if (r < 90) queue_length($urandom_range(0, 63), $urandom_range(7, 20));
        else if (r < 97) queue_length($urandom_range(0, 63), $urandom_range(21, 64));
        else             queue_length($urandom_range(0, 63), $urandom_range(65, 127));
      end else if (r < 70) begin
        queue_ignored();
      end else begin
        r = $urandom_range(0, 3);
        if (r == 0)      fr = $urandom_range(0, 200);
        else if (r == 1) fr = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else             fr = $urandom;
        queue_tick(fr, FracW'($urandom));
      end
    end
    total_beats = pending_beats.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stim_ready = 1'b1;

    while (beats_accepted < total_beats) @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatch_cnt == 0 && expected_levels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
